// ----- hw/rtl/ptr_pkg.sv -----
// ptr_pkg: shared types, opcodes and constants of the paper tape reader interface
// no dependencies; used by ptr_cfg, ptr_core and paper_tape_reader_interface
`default_nettype none

package ptr_pkg;

    // bus opcodes
    localparam logic [2:0] OP_INPUT      = 3'd0;
    localparam logic [2:0] OP_START      = 3'd1;
    localparam logic [2:0] OP_STOP       = 3'd2;
    localparam logic [2:0] OP_SKIP_READY = 3'd3;
    localparam logic [2:0] OP_SKIP_NOIRQ = 3'd4;
    localparam logic [2:0] OP_SET_MASK   = 3'd5;
    localparam logic [2:0] OP_CHAR_TIME  = 3'd6;
    localparam logic [2:0] OP_CLEAR      = 3'd7;

    // configuration register indexes
    localparam logic REG_ASCII_MODE     = 1'b0;
    localparam logic REG_END_POLL_LIMIT = 1'b1;

    localparam int          CFG_DATA_W         = 16;
    localparam logic [15:0] END_POLL_LIMIT_RST = 16'd1000;
    localparam logic [15:0] END_POLLS_MAX      = 16'hffff;

    localparam int       MAX_PENDING_DEF = 3;
    localparam int       MASK_BIT_POS    = 7;
    localparam logic [7:0] CODE_CR       = 8'o215;
    localparam logic [7:0] CODE_LF       = 8'o212;
    localparam logic [7:0] CODE_NL       = 8'h0a;
    localparam logic [7:0] HIGH_BIT      = 8'h80;

    typedef struct packed {
        logic        ascii_mode;
        logic [15:0] end_poll_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] mask_word;
        logic [7:0]  tape_byte;
        logic        tape_end;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       condition;
        logic       schedule_char;
        logic       tape_taken;
        logic       new_tape_request;
        logic       overrun;
        logic       irq;
    } rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ptr_if.sv -----
// ptr_req_if and ptr_rsp_if: valid/ready channels of the paper tape reader interface
// no dependencies
`default_nettype none

interface ptr_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] mask_word;
    logic [7:0]  tape_byte;
    logic        tape_end;

    modport source (output valid, output opcode, output mask_word, output tape_byte,
                    output tape_end, input ready);
    modport sink (input valid, input opcode, input mask_word, input tape_byte,
                  input tape_end, output ready);
endinterface

interface ptr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       condition;
    logic       schedule_char;
    logic       tape_taken;
    logic       new_tape_request;
    logic       overrun;
    logic       irq;

    modport source (output valid, output read_data, output condition,
                    output schedule_char, output tape_taken, output new_tape_request,
                    output overrun, output irq, input ready);
    modport sink (input valid, input read_data, input condition, input schedule_char,
                  input tape_taken, input new_tape_request, input overrun, input irq,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ptr_cfg.sv -----
// ptr_cfg: configuration registers written through the plain write port
// depends on ptr_pkg
`default_nettype none

module ptr_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic                         wr_index,
    input  wire logic [ptr_pkg::CFG_DATA_W-1:0] wr_data,
    output ptr_pkg::cfg_t                     cfg
);

    logic        ascii_mode_reg;
    logic [15:0] end_poll_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascii_mode_reg     <= 1'b0;
            end_poll_limit_reg <= ptr_pkg::END_POLL_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ptr_pkg::REG_ASCII_MODE:     ascii_mode_reg     <= wr_data[0];
                ptr_pkg::REG_END_POLL_LIMIT: end_poll_limit_reg <= wr_data[15:0];
                default:                     ;
            endcase
        end
    end

    assign cfg.ascii_mode     = ascii_mode_reg;
    assign cfg.end_poll_limit = end_poll_limit_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ptr_core.sv -----
// ptr_core: reader state and the combinational update for one request
// depends on ptr_pkg
`default_nettype none

module ptr_core #(
    parameter int MAX_PENDING = ptr_pkg::MAX_PENDING_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire ptr_pkg::item_t item,
    input  wire ptr_pkg::cfg_t  cfg,
    output ptr_pkg::rsp_t       rsp_next
);

    localparam int PW = $clog2(MAX_PENDING + 1);
    localparam logic [PW-1:0] PEND_MAX = PW'(MAX_PENDING);

    logic          char_ready_reg,      char_ready_next;
    logic [7:0]    char_buffer_reg,     char_buffer_next;
    logic          irq_enable_reg,      irq_enable_next;
    logic          tape_loaded_reg,     tape_loaded_next;
    logic          motor_on_reg,        motor_on_next;
    logic          skip_next_event_reg, skip_next_event_next;
    logic [PW-1:0] pending_events_reg,  pending_events_next;
    logic          at_end_reg,          at_end_next;
    logic [15:0]   end_polls_reg,       end_polls_next;
    logic          line_feed_due_reg,   line_feed_due_next;

    logic [15:0]   polls_inc;
    logic [PW-1:0] pend_inc;
    logic [PW-1:0] pend_dec;
    logic [PW-1:0] pend_dec_inc;
    logic [7:0]    char_in;
    logic          got_char;

    // saturating counters
    assign polls_inc    = (end_polls_reg == ptr_pkg::END_POLLS_MAX) ? end_polls_reg
                                                                    : end_polls_reg + 16'd1;
    assign pend_inc     = (pending_events_reg < PEND_MAX) ? pending_events_reg + PW'(1)
                                                          : pending_events_reg;
    assign pend_dec     = (pending_events_reg != '0) ? pending_events_reg - PW'(1) : '0;
    assign pend_dec_inc = (pend_dec < PEND_MAX) ? pend_dec + PW'(1) : pend_dec;

    always_comb
    begin
        char_ready_next      = char_ready_reg;
        char_buffer_next     = char_buffer_reg;
        irq_enable_next      = irq_enable_reg;
        tape_loaded_next     = tape_loaded_reg;
        motor_on_next        = motor_on_reg;
        skip_next_event_next = skip_next_event_reg;
        pending_events_next  = pending_events_reg;
        at_end_next          = at_end_reg;
        end_polls_next       = end_polls_reg;
        line_feed_due_next   = line_feed_due_reg;

        rsp_next.read_data        = 8'd0;
        rsp_next.condition        = 1'b0;
        rsp_next.schedule_char    = 1'b0;
        rsp_next.tape_taken       = 1'b0;
        rsp_next.new_tape_request = 1'b0;
        rsp_next.overrun          = 1'b0;
        char_in                   = 8'd0;
        got_char                  = 1'b1;

        unique case (item.opcode)
            ptr_pkg::OP_INPUT:
            begin
                rsp_next.condition = char_ready_reg;
                if (char_ready_reg)
                begin
                    rsp_next.read_data = char_buffer_reg;
                    char_ready_next    = 1'b0;
                end
                else if (at_end_reg)
                begin
                    end_polls_next = polls_inc;
                    // poll limit passed: reload the tape and run the motor
                    if (polls_inc > cfg.end_poll_limit)
                    begin
                        rsp_next.new_tape_request = 1'b1;
                        tape_loaded_next          = 1'b1;
                        at_end_next               = 1'b0;
                        end_polls_next            = 16'd0;
                        rsp_next.schedule_char    = 1'b1;
                        pending_events_next       = pend_inc;
                        motor_on_next             = 1'b1;
                    end
                end
            end
            ptr_pkg::OP_START:
            begin
                rsp_next.condition = 1'b1;
                // a tape that ran off its end counts as unloaded
                if (!tape_loaded_reg || at_end_reg)
                begin
                    rsp_next.new_tape_request = 1'b1;
                    tape_loaded_next          = 1'b1;
                    at_end_next               = 1'b0;
                    end_polls_next            = 16'd0;
                end
                if (!motor_on_reg)
                begin
                    rsp_next.schedule_char = 1'b1;
                    pending_events_next    = pend_inc;
                    motor_on_next          = 1'b1;
                end
            end
            ptr_pkg::OP_STOP:
            begin
                rsp_next.condition = 1'b1;
                motor_on_next      = 1'b0;
                if (pending_events_reg != '0)
                    skip_next_event_next = 1'b1;
            end
            ptr_pkg::OP_SKIP_READY:
                rsp_next.condition = char_ready_reg;
            ptr_pkg::OP_SKIP_NOIRQ:
                rsp_next.condition = !(char_ready_reg && irq_enable_reg);
            ptr_pkg::OP_SET_MASK:
            begin
                rsp_next.condition = 1'b1;
                irq_enable_next    = item.mask_word[ptr_pkg::MASK_BIT_POS];
            end
            ptr_pkg::OP_CHAR_TIME:
            begin
                pending_events_next  = pend_dec;
                skip_next_event_next = 1'b0;
                if (!skip_next_event_reg)
                begin
                    rsp_next.overrun = char_ready_reg;
                    if (line_feed_due_reg)
                    begin
                        char_in            = ptr_pkg::CODE_LF;
                        line_feed_due_next = 1'b0;
                    end
                    else if (!tape_loaded_reg || item.tape_end)
                    begin
                        got_char = 1'b0;
                    end
                    else
                    begin
                        rsp_next.tape_taken = 1'b1;
                        char_in             = item.tape_byte;
                        if (cfg.ascii_mode)
                        begin
                            if (item.tape_byte == ptr_pkg::CODE_NL)
                            begin
                                char_in            = ptr_pkg::CODE_CR;
                                line_feed_due_next = 1'b1;
                            end
                            else if (item.tape_byte != 8'd0)
                            begin
                                char_in = item.tape_byte | ptr_pkg::HIGH_BIT;
                            end
                        end
                    end
                    if (got_char)
                    begin
                        char_buffer_next       = char_in;
                        char_ready_next        = 1'b1;
                        rsp_next.schedule_char = 1'b1;
                        pending_events_next    = pend_dec_inc;
                    end
                    else
                    begin
                        at_end_next    = 1'b1;
                        end_polls_next = 16'd0;
                    end
                end
            end
            ptr_pkg::OP_CLEAR:
            begin
                char_ready_next      = 1'b0;
                char_buffer_next     = 8'd0;
                irq_enable_next      = 1'b0;
                tape_loaded_next     = 1'b0;
                motor_on_next        = 1'b0;
                skip_next_event_next = 1'b0;
                pending_events_next  = '0;
                at_end_next          = 1'b0;
                end_polls_next       = 16'd0;
                line_feed_due_next   = 1'b0;
            end
            default: ;
        endcase

        rsp_next.irq = char_ready_next && irq_enable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_ready_reg      <= 1'b0;
            char_buffer_reg     <= 8'd0;
            irq_enable_reg      <= 1'b0;
            tape_loaded_reg     <= 1'b0;
            motor_on_reg        <= 1'b0;
            skip_next_event_reg <= 1'b0;
            pending_events_reg  <= '0;
            at_end_reg          <= 1'b0;
            end_polls_reg       <= 16'd0;
            line_feed_due_reg   <= 1'b0;
        end
        else if (fire)
        begin
            char_ready_reg      <= char_ready_next;
            char_buffer_reg     <= char_buffer_next;
            irq_enable_reg      <= irq_enable_next;
            tape_loaded_reg     <= tape_loaded_next;
            motor_on_reg        <= motor_on_next;
            skip_next_event_reg <= skip_next_event_next;
            pending_events_reg  <= pending_events_next;
            at_end_reg          <= at_end_next;
            end_polls_reg       <= end_polls_next;
            line_feed_due_reg   <= line_feed_due_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/paper_tape_reader_interface.sv -----
// paper_tape_reader_interface: top level with request register, core and result register
// depends on ptr_pkg, ptr_if (ptr_req_if, ptr_rsp_if), ptr_cfg and ptr_core
`default_nettype none

// Bus interface of a paper tape reader. Every request (input, start, stop, the two
// skips, set mask, character time, master clear) gives exactly one result. A request
// is captured in an input register, processed against the reader state, and its
// result lands in an output register; a request moves from the input register into
// the output register only while the output register is free, and one request is
// accepted every cycle as long as the result side keeps taking results. The rate is
// set by the state update in ptr_core: each request reads and writes the state in
// the cycle it is processed, so the next request always sees it. The configuration
// registers (ascii_mode at index 0, end_poll_limit at index 1) are written through
// wr_en/wr_index/wr_data and should only change while no request is in flight.
// Master clear resets the reader state but keeps the configuration.
module paper_tape_reader_interface #(
    parameter int MAX_PENDING = ptr_pkg::MAX_PENDING_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ptr_req_if.sink                             req,
    ptr_rsp_if.source                           rsp,
    input  wire logic                           wr_en,
    input  wire logic                           wr_index,
    input  wire logic [ptr_pkg::CFG_DATA_W-1:0] wr_data
);

    ptr_pkg::cfg_t  cfg;
    ptr_pkg::item_t item_reg;
    ptr_pkg::rsp_t  rsp_reg;
    ptr_pkg::rsp_t  rsp_next;

    logic item_valid_reg;
    logic rsp_valid_reg;
    logic out_free;
    logic fire;

    // result register can take a new result this cycle
    assign out_free = !rsp_valid_reg || rsp.ready;
    // request in the input register is processed
    assign fire     = item_valid_reg && out_free;
    // input register frees up whenever its request moves on
    assign req.ready = !item_valid_reg || out_free;

    // configuration registers
    ptr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (req.ready)
            item_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.opcode    <= req.opcode;
            item_reg.mask_word <= req.mask_word;
            item_reg.tape_byte <= req.tape_byte;
            item_reg.tape_end  <= req.tape_end;
        end
    end

    // reader state and per-request decode
    ptr_core #(
        .MAX_PENDING (MAX_PENDING)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item_reg),
        .cfg      (cfg),
        .rsp_next (rsp_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (out_free)
            rsp_valid_reg <= fire;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            rsp_reg <= rsp_next;
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.read_data        = rsp_reg.read_data;
    assign rsp.condition        = rsp_reg.condition;
    assign rsp.schedule_char    = rsp_reg.schedule_char;
    assign rsp.tape_taken       = rsp_reg.tape_taken;
    assign rsp.new_tape_request = rsp_reg.new_tape_request;
    assign rsp.overrun          = rsp_reg.overrun;
    assign rsp.irq              = rsp_reg.irq;

`ifndef ASSERT_OFF
    // a held request is never overwritten by a new one
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !fire |-> !req.ready)
        else $error("input register overwritten while held");

    // a consumed tape byte always yields a character and schedules the next one
    a_taken_sched: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.tape_taken |-> rsp.schedule_char)
        else $error("tape byte taken without scheduling");

    // data is only delivered by an input that found ready
    a_data_cond: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.read_data != 8'd0) |-> rsp.condition)
        else $error("read data without ready condition");

    // overrun only comes from a character time, whose condition is low
    a_overrun_cond: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.overrun |-> !rsp.condition && !rsp.new_tape_request)
        else $error("overrun on a request other than character time");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_paper_tape_reader_interface.sv -----
`timescale 1ns / 100ps
// tb_paper_tape_reader_interface: self-checking bench for the paper tape reader bus block,
// with directed and random request streams, random stalls and a built-in predictor
// depends on ptr_pkg, ptr_if (ptr_req_if, ptr_rsp_if) and paper_tape_reader_interface

module tb_paper_tape_reader_interface;

    localparam int PENDING_LIMIT = ptr_pkg::MAX_PENDING_DEF;

    // predictor copy of the reader state
    typedef struct packed {
        logic       have_char;
        logic [7:0] char_latch;
        logic       mask_on;
        logic       tape_in;
        logic       motor_running;
        logic       drop_next_event;
        logic [3:0] queued_events;
        logic       tape_out;
        logic [15:0] polls_after_end;
        logic       lf_pending;
    } tape_reader_state_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic wr_index;
    logic [ptr_pkg::CFG_DATA_W-1:0] wr_data;

    ptr_req_if req_ch ();
    ptr_rsp_if rsp_ch ();

    paper_tape_reader_interface #(
        .MAX_PENDING(PENDING_LIMIT)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    tape_reader_state_t reader = '0;
    logic               text_mode = 1'b0;
    logic [15:0]        poll_limit = ptr_pkg::END_POLL_LIMIT_RST;

    ptr_pkg::rsp_t expected_reader_results[$];
    int unsigned   mismatch_count = 0;
    int unsigned   requests_sent = 0;

    // idling switches and the long receiver hold-off, counted down by the ready process
    bit sender_idles = 1'b0;
    bit receiver_idles = 1'b0;
    int unsigned ready_hold_cycles = 0;

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // pending character times saturate at the limit
    function automatic void count_event();
        if (reader.queued_events < PENDING_LIMIT)
            reader.queued_events = reader.queued_events + 4'd1;
    endfunction

    function automatic void mount_tape(inout ptr_pkg::rsp_t res);
        res.new_tape_request   = 1'b1;
        reader.tape_in         = 1'b1;
        reader.tape_out        = 1'b0;
        reader.polls_after_end = '0;
    endfunction

    function automatic void spin_motor(inout ptr_pkg::rsp_t res);
        res.schedule_char    = 1'b1;
        count_event();
        reader.motor_running = 1'b1;
    endfunction

    function automatic ptr_pkg::rsp_t predict_reader_result(input ptr_pkg::item_t it);
        ptr_pkg::rsp_t res;
        logic [7:0]    ch;
        logic          got;
        res = '0;
        case (it.opcode)
            ptr_pkg::OP_INPUT:
            begin
                res.condition = reader.have_char;
                if (reader.have_char)
                begin
                    res.read_data    = reader.char_latch;
                    reader.have_char = 1'b0;
                end
                else if (reader.tape_out)
                begin
                    // poll count sticks at its maximum
                    if (reader.polls_after_end != ptr_pkg::END_POLLS_MAX)
                        reader.polls_after_end = reader.polls_after_end + 16'd1;
                    if (reader.polls_after_end > poll_limit)
                    begin
                        mount_tape(res);
                        spin_motor(res);
                    end
                end
            end
            ptr_pkg::OP_START:
            begin
                if (reader.tape_in && reader.tape_out)
                    reader.tape_in = 1'b0;
                if (!reader.tape_in)
                    mount_tape(res);
                if (!reader.motor_running)
                    spin_motor(res);
                res.condition = 1'b1;
            end
            ptr_pkg::OP_STOP:
            begin
                reader.motor_running = 1'b0;
                if (reader.queued_events != 0)
                    reader.drop_next_event = 1'b1;
                res.condition = 1'b1;
            end
            ptr_pkg::OP_SKIP_READY:
                res.condition = reader.have_char;
            ptr_pkg::OP_SKIP_NOIRQ:
                res.condition = !(reader.have_char && reader.mask_on);
            ptr_pkg::OP_SET_MASK:
            begin
                reader.mask_on = it.mask_word[ptr_pkg::MASK_BIT_POS];
                res.condition  = 1'b1;
            end
            ptr_pkg::OP_CHAR_TIME:
            begin
                if (reader.queued_events != 0)
                    reader.queued_events = reader.queued_events - 4'd1;
                // an event after a stop with one pending is swallowed
                if (!reader.drop_next_event)
                begin
                    got = 1'b1;
                    ch  = '0;
                    res.overrun = reader.have_char;
                    if (reader.lf_pending)
                    begin
                        ch = ptr_pkg::CODE_LF;
                        reader.lf_pending = 1'b0;
                    end
                    else if (!reader.tape_in || it.tape_end)
                        got = 1'b0;
                    else
                    begin
                        res.tape_taken = 1'b1;
                        ch = it.tape_byte;
                        if (text_mode)
                        begin
                            if (ch == ptr_pkg::CODE_NL)
                            begin
                                ch = ptr_pkg::CODE_CR;
                                reader.lf_pending = 1'b1;
                            end
                            else if (ch != 8'h00)
                                ch = ch | ptr_pkg::HIGH_BIT;
                        end
                    end
                    if (got)
                    begin
                        reader.char_latch = ch;
                        reader.have_char  = 1'b1;
                        res.schedule_char = 1'b1;
                        count_event();
                    end
                    else
                    begin
                        reader.tape_out        = 1'b1;
                        reader.polls_after_end = '0;
                    end
                end
                reader.drop_next_event = 1'b0;
            end
            ptr_pkg::OP_CLEAR:
                reader = '0;
            default:
                reader = '0;
        endcase
        res.irq = reader.have_char && reader.mask_on;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns  mismatch: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // results are checked before the request of the same edge is predicted;
    // the block never answers in the cycle it takes a request
    always @(posedge clk)
    begin
        ptr_pkg::rsp_t  want;
        ptr_pkg::item_t seen;
        if (rst_n === 1'b1)
        begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (expected_reader_results.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want = expected_reader_results.pop_front();
                    compare_field("read_data", rsp_ch.read_data, want.read_data);
                    compare_field("condition", 8'(rsp_ch.condition), 8'(want.condition));
                    compare_field("schedule_char", 8'(rsp_ch.schedule_char),
                                  8'(want.schedule_char));
                    compare_field("tape_taken", 8'(rsp_ch.tape_taken),
                                  8'(want.tape_taken));
                    compare_field("new_tape_request", 8'(rsp_ch.new_tape_request),
                                  8'(want.new_tape_request));
                    compare_field("overrun", 8'(rsp_ch.overrun), 8'(want.overrun));
                    compare_field("irq", 8'(rsp_ch.irq), 8'(want.irq));
                end
            end
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            begin
                seen.opcode    = req_ch.opcode;
                seen.mask_word = req_ch.mask_word;
                seen.tape_byte = req_ch.tape_byte;
                seen.tape_end  = req_ch.tape_end;
                expected_reader_results.push_back(predict_reader_result(seen));
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random gap after each result, plus the long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned ready_gap;
        ready_gap = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                ready_gap = receiver_idles ? $urandom_range(0, 11) : 0;
            if (ready_hold_cycles > 0)
            begin
                ready_hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // valid stays high into the next request when no gap is drawn
    task automatic send_request(input ptr_pkg::item_t it);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= it.opcode;
        req_ch.mask_word <= it.mask_word;
        req_ch.tape_byte <= it.tape_byte;
        req_ch.tape_end  <= it.tape_end;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        requests_sent++;
    endtask

    function automatic ptr_pkg::item_t make_request(input logic [2:0] op,
                                                    input logic [15:0] mask,
                                                    input logic [7:0] tbyte,
                                                    input logic tend);
        ptr_pkg::item_t it;
        it.opcode    = op;
        it.mask_word = mask;
        it.tape_byte = tbyte;
        it.tape_end  = tend;
        return it;
    endfunction

    // newlines and nul bytes show up often to exercise the text translation
    function automatic logic [7:0] pick_tape_byte();
        case ($urandom_range(0, 9))
            0, 1:    return ptr_pkg::CODE_NL;
            2:       return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // request with random mask word and tape byte; tape_end comes from the caller
    task automatic send_op(input logic [2:0] op, input logic tend);
        send_request(make_request(op, 16'($urandom_range(0, 65535)), pick_tape_byte(),
                                  tend));
    endtask

    // stop offering and wait until every expected result is in, or until the wait gives up
    task automatic wait_for_results_drained();
        int unsigned waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_reader_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // both registers in consecutive cycles; only called with the block idle
    task automatic set_reader_config(input logic ascii, input logic [15:0] limit);
        wr_en    <= 1'b1;
        wr_index <= ptr_pkg::REG_ASCII_MODE;
        wr_data  <= {15'($urandom_range(0, 32767)), ascii};
        @(posedge clk);
        wr_index <= ptr_pkg::REG_END_POLL_LIMIT;
        wr_data  <= limit;
        text_mode = ascii;
        @(posedge clk);
        wr_en <= 1'b0;
        poll_limit = limit;
    endtask

    // one tape pass: optional mask, start, characters read or skipped, usually an end of
    // tape with polling, sometimes a stop that swallows the next event, rarely a clear
    task automatic run_reading_session();
        int unsigned len;
        int unsigned polls;
        if ($urandom_range(0, 2) == 0)
            send_op(ptr_pkg::OP_SET_MASK, 1'($urandom_range(0, 1)));
        send_op(ptr_pkg::OP_START, 1'($urandom_range(0, 1)));
        len = $urandom_range(1, 16);
        repeat (len)
        begin
            send_op(ptr_pkg::OP_CHAR_TIME, ($urandom_range(0, 19) == 0));
            case ($urandom_range(0, 9))
                6: send_op(ptr_pkg::OP_SKIP_READY, 1'($urandom_range(0, 1)));
                7: send_op(ptr_pkg::OP_SKIP_NOIRQ, 1'($urandom_range(0, 1)));
                8: ;  // leave the character unread, next one overruns
                9:
                begin
                    send_op(ptr_pkg::OP_INPUT, 1'($urandom_range(0, 1)));
                    send_op(ptr_pkg::OP_INPUT, 1'($urandom_range(0, 1)));
                end
                default: send_op(ptr_pkg::OP_INPUT, 1'($urandom_range(0, 1)));
            endcase
        end
        if ($urandom_range(0, 3) != 0)
        begin
            send_op(ptr_pkg::OP_CHAR_TIME, 1'b1);
            polls = (poll_limit <= 16'd8) ? $urandom_range(0, poll_limit + 2)
                                          : $urandom_range(0, 3);
            repeat (polls) send_op(ptr_pkg::OP_INPUT, 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            send_op(ptr_pkg::OP_STOP, 1'($urandom_range(0, 1)));
            send_op(ptr_pkg::OP_CHAR_TIME, 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 15) == 0)
            send_op(ptr_pkg::OP_CLEAR, 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-built walk through every opcode and the corner cases
    task automatic test_directed_cases();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        set_reader_config(1'b1, 16'd1);
        // character time without a tape counts as end of tape; pending count stays 0
        send_request(make_request(ptr_pkg::OP_CHAR_TIME, 16'h0000, 8'h41, 1'b0));
        // two polls pass a limit of one: new tape and motor restart
        send_request(make_request(ptr_pkg::OP_INPUT, 16'hffff, 8'hff, 1'b1));
        send_request(make_request(ptr_pkg::OP_INPUT, 16'h0000, 8'h00, 1'b0));
        send_request(make_request(ptr_pkg::OP_SET_MASK, 16'hffff, 8'h00, 1'b0));
        // newline in text mode: carriage return now, line feed on the next event
        send_request(make_request(ptr_pkg::OP_CHAR_TIME, 16'h0000, ptr_pkg::CODE_NL, 1'b0));
        send_request(make_request(ptr_pkg::OP_SKIP_READY, 16'h0000, 8'h00, 1'b0));
        send_request(make_request(ptr_pkg::OP_SKIP_NOIRQ, 16'h0000, 8'h00, 1'b0));
        // line feed arrives on top of the unread carriage return: overrun
        send_request(make_request(ptr_pkg::OP_CHAR_TIME, 16'h0000, 8'h55, 1'b0));
        send_request(make_request(ptr_pkg::OP_INPUT, 16'h0000, 8'h00, 1'b0));
        // nul keeps its high bit clear, all-ones stays as is
        send_request(make_request(ptr_pkg::OP_CHAR_TIME, 16'h0000, 8'h00, 1'b0));
        send_request(make_request(ptr_pkg::OP_INPUT, 16'h0000, 8'h00, 1'b0));
        send_request(make_request(ptr_pkg::OP_CHAR_TIME, 16'h0000, 8'hff, 1'b0));
        // mask bit alone cleared
        send_request(make_request(ptr_pkg::OP_SET_MASK, 16'hff7f, 8'h00, 1'b0));
        send_request(make_request(ptr_pkg::OP_SKIP_NOIRQ, 16'h0000, 8'h00, 1'b0));
        // stop with an event pending: the next character time is ignored
        send_request(make_request(ptr_pkg::OP_STOP, 16'h0000, 8'h00, 1'b0));
        send_request(make_request(ptr_pkg::OP_CHAR_TIME, 16'h0000, 8'h33, 1'b0));
        // stop/start pairs pile up pending events until the count saturates
        repeat (4)
        begin
            send_request(make_request(ptr_pkg::OP_START, 16'h0000, 8'h00, 1'b0));
            send_request(make_request(ptr_pkg::OP_STOP, 16'h0000, 8'h00, 1'b0));
        end
        send_request(make_request(ptr_pkg::OP_CHAR_TIME, 16'h0000, 8'h11, 1'b0));
        // end of tape, then a start reloads the tape
        send_request(make_request(ptr_pkg::OP_CHAR_TIME, 16'h0000, 8'h22, 1'b1));
        send_request(make_request(ptr_pkg::OP_START, 16'h0000, 8'h00, 1'b0));
        // master clear and a character time with no tape left
        send_request(make_request(ptr_pkg::OP_CLEAR, 16'hffff, 8'hff, 1'b1));
        send_request(make_request(ptr_pkg::OP_CHAR_TIME, 16'h0000, 8'h7e, 1'b0));
        wait_for_results_drained();
    endtask

    // random sessions and noise over several register settings
    task automatic test_tape_sessions();
        int unsigned phase_end;
        bit          paused;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       set_reader_config(1'b0, 16'd65534);
                1:       set_reader_config(1'b1, 16'd1);
                2:       set_reader_config(1'b1, 16'($urandom_range(2, 6)));
                3:       set_reader_config(1'b0, 16'($urandom_range(1, 4)));
                4:       set_reader_config(1'b1, 16'd65534);
                default: set_reader_config(1'($urandom_range(0, 1)),
                                           16'($urandom_range(1, 8)));
            endcase
            // idling on each side follows the low bits of the phase number
            sender_idles   = p[0];
            receiver_idles = p[0] ^ p[1];
            phase_end = requests_sent + 225;
            paused    = 1'b0;
            while (requests_sent < phase_end)
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 8))
                        send_op(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                else
                    run_reading_session();
                // halfway through, the sender waits for every result before going on
                if (!paused && requests_sent + 110 >= phase_end)
                begin
                    wait_for_results_drained();
                    paused = 1'b1;
                end
            end
            wait_for_results_drained();
        end
    endtask

    // receiver holds off long enough that the block fills and stalls requests
    task automatic test_output_stall();
        int unsigned stall_end;
        sender_idles      = 1'b0;
        receiver_idles    = 1'b0;
        ready_hold_cycles = 60;
        stall_end = requests_sent + 40;
        while (requests_sent < stall_end)
            run_reading_session();
        wait_for_results_drained();
        receiver_idles = 1'b1;
        sender_idles   = 1'b1;
        stall_end = requests_sent + 30;
        ready_hold_cycles = 45;
        while (requests_sent < stall_end)
            run_reading_session();
        wait_for_results_drained();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        wr_en            <= 1'b0;
        wr_index         <= ptr_pkg::REG_ASCII_MODE;
        wr_data          <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.opcode    <= ptr_pkg::OP_INPUT;
        req_ch.mask_word <= '0;
        req_ch.tape_byte <= '0;
        req_ch.tape_end  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_output_stall();
        test_tape_sessions();

        // trailing cycles catch any spurious result after the last one
        wait_for_results_drained();
        repeat (6) @(posedge clk);
        if (expected_reader_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_reader_results.size()));
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
